@@ rtl/bdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdeq_pkg: shared types and codes of the bounded double-ended queue
// Holds the request and response payloads, the action and status codes,
// and the link type of the modulo cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bdeq_pkg;

	localparam int ACT_W  = 3;
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 16;
	localparam int STAT_W = 2;
	localparam int CAP_W  = 9;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ       = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [VAL_W-1:0] item_value;
		logic [IDX_W-1:0] read_index;
	} bdeq_req_t;

	typedef struct packed {
		logic [VAL_W-1:0]  read_value;
		logic [STAT_W-1:0] status;
		logic [CAP_W-1:0]  element_count;
	} bdeq_rsp_t;

	// One link of the modulo chain: partial remainder and the index bits left.
	typedef struct packed {
		logic             valid;
		logic [CAP_W-1:0] rem;
		logic [IDX_W-1:0] idx;
	} bdeq_cell_t;

endpackage

`default_nettype wire

@@ rtl/bdeq_mod_cell.sv @@
// ----------------------------------------------------------------------------
// bdeq_mod_cell: one step of the index modulo chain
// Shifts in the next index bit and subtracts the capacity when the partial
// remainder reaches it; registers the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bdeq_mod_cell (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire logic [bdeq_pkg::CAP_W-1:0]      cap,
	input  wire bdeq_pkg::bdeq_cell_t            prev,
	output bdeq_pkg::bdeq_cell_t                 next
);

	logic                         valid_q;
	logic [bdeq_pkg::CAP_W-1:0]   rem_q;
	logic [bdeq_pkg::IDX_W-1:0]   idx_q;
	logic [bdeq_pkg::CAP_W:0]     shifted;
	logic [bdeq_pkg::CAP_W-1:0]   rem_nxt;

	always_comb begin
		shifted = {prev.rem, prev.idx[bdeq_pkg::IDX_W-1]};
		if (shifted >= {1'b0, cap}) begin
			rem_nxt = bdeq_pkg::CAP_W'(shifted - {1'b0, cap});
		end else begin
			rem_nxt = shifted[bdeq_pkg::CAP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_nxt;
		idx_q <= {prev.idx[bdeq_pkg::IDX_W-2:0], 1'b0};
	end

	assign next.valid = valid_q;
	assign next.rem   = rem_q;
	assign next.idx   = idx_q;

endmodule

`default_nettype wire

@@ rtl/bdeq_store.sv @@
// ----------------------------------------------------------------------------
// bdeq_store: element ring storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bdeq_store #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire                             clk,
	input  wire                             wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [DATA_WIDTH-1:0]      wr_data,
	input  wire                             rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [DATA_WIDTH-1:0]      rd_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/bounded_double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_queue: bounded deque over a ring buffer
// Push and pop at both ends, read by logical index modulo the capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries one action:
//   push front, push back, pop front, pop back or read by index. Response
//   channel (rsp_valid / rsp_stall / rsp_data) returns exactly one response
//   per request: value read or popped, status and element count after it.
//   The capacity register is written on cfg_valid (cfg_ready is always high);
//   lowering it drops back entries. The user must write it only while no
//   request is outstanding; the block itself does not enforce this.
// Sequence: push and unused codes pass the access state, pop the access and
//   fetch states (store read is registered). Read by index waits in the
//   modulo state on the 16-cell chain, one index bit per cell, then access
//   and fetch, or skips to the response if the position is empty. One request
//   is in flight at a time; the next is taken in the cycle the response leaves.
// Reset: queue empty, front at ring slot 0, capacity at DEPTH (at most 511).
//   The store itself is not cleared; no unwritten slot is ever returned.
// Stalled receiver: the response is held in its register and no new request
//   is taken until it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   req_valid,
	output logic                                  req_stall,
	input  wire bdeq_pkg::bdeq_req_t              req_data,
	output logic                                  rsp_valid,
	input  wire                                   rsp_stall,
	output bdeq_pkg::bdeq_rsp_t                   rsp_data,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bdeq_pkg::CAP_W-1:0]       cfg_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > bdeq_pkg::CAP_W) ? CNT_W : bdeq_pkg::CAP_W;
	localparam int CAP_MAX = (1 << bdeq_pkg::CAP_W) - 1;
	localparam int CAP_RESET = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_MOD    = 5'b00010,
		S_ACCESS = 5'b00100,
		S_FETCH  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                          state_q, state_nxt;
	logic [bdeq_pkg::ACT_W-1:0]      act_q;
	logic [bdeq_pkg::VAL_W-1:0]      item_q;
	logic [CNT_W-1:0]                offset_q;
	logic [PTR_W-1:0]                front_q, front_nxt, front_inc;
	logic [CNT_W-1:0]                count_q, count_nxt;
	logic [bdeq_pkg::CAP_W-1:0]      cap_q, cap_new;
	bdeq_pkg::bdeq_rsp_t             rsp_q;

	logic                            req_accept;
	logic                            is_full, is_empty, rd_miss;
	logic [SUM_W-1:0]                sum;
	logic [PTR_W-1:0]                ring_addr;
	logic [bdeq_pkg::STAT_W-1:0]     st_nxt;
	logic                            op_wr, op_rd, wr_en, rd_en;
	logic [CNT_W-1:0]                offset_new;
	logic [DATA_WIDTH-1:0]           rd_data;

	bdeq_pkg::bdeq_cell_t            link [bdeq_pkg::IDX_W+1];

	// Handshakes: take a request when idle, or as the held response leaves.
	assign req_accept = req_valid && !req_stall;
	assign req_stall  = !((state_q == S_IDLE) || ((state_q == S_DONE) && !rsp_stall));
	assign rsp_valid  = (state_q == S_DONE);
	assign rsp_data   = rsp_q;
	assign cfg_ready  = 1'b1;

	// Clamp the written capacity into 1..DEPTH.
	always_comb begin
		if (cfg_data == '0) begin
			cap_new = bdeq_pkg::CAP_W'(1);
		end else if (CMP_W'(cfg_data) > CMP_W'(DEPTH)) begin
			cap_new = bdeq_pkg::CAP_W'(DEPTH);
		end else begin
			cap_new = cfg_data;
		end
	end

	// Modulo chain: read_index mod capacity, one index bit per cell.
	assign link[0].valid = req_accept && (req_data.action == bdeq_pkg::ACT_READ);
	assign link[0].rem   = '0;
	assign link[0].idx   = req_data.read_index;

	for (genvar g = 0; g < bdeq_pkg::IDX_W; g++) begin : g_cell
		bdeq_mod_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cap    (cap_q),
			.prev   (link[g]),
			.next   (link[g+1])
		);
	end

	// Logical position past the last element reads as empty.
	assign rd_miss = CMP_W'(link[bdeq_pkg::IDX_W].rem) >= CMP_W'(count_q);

	// Ring offset of each action's slot at accept; a read later takes the remainder.
	always_comb begin
		case (req_data.action)
			bdeq_pkg::ACT_PUSH_FRONT: offset_new = CNT_W'(DEPTH - 1);
			bdeq_pkg::ACT_PUSH_BACK:  offset_new = count_q;
			bdeq_pkg::ACT_POP_BACK:   offset_new = count_q - CNT_W'(1);
			default:                  offset_new = '0;
		endcase
	end

	// Ring address = (front + offset) mod DEPTH; a used sum stays below 2*DEPTH.
	always_comb begin
		sum = SUM_W'(front_q) + SUM_W'(offset_q);
		if (sum >= SUM_W'(DEPTH)) begin
			ring_addr = PTR_W'(sum - SUM_W'(DEPTH));
		end else begin
			ring_addr = PTR_W'(sum);
		end
		front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + PTR_W'(1);
	end

	// Effect of the held action, applied in the access cycle.
	always_comb begin
		is_full   = CMP_W'(count_q) >= CMP_W'(cap_q);
		is_empty  = (count_q == '0);
		count_nxt = count_q;
		front_nxt = front_q;
		st_nxt    = bdeq_pkg::ST_OK;
		op_wr     = 1'b0;
		op_rd     = 1'b0;
		case (act_q)
			bdeq_pkg::ACT_PUSH_FRONT: begin
				if (is_full) begin
					st_nxt = bdeq_pkg::ST_FULL;
				end else begin
					op_wr     = 1'b1;
					front_nxt = ring_addr;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			bdeq_pkg::ACT_PUSH_BACK: begin
				if (is_full) begin
					st_nxt = bdeq_pkg::ST_FULL;
				end else begin
					op_wr     = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			bdeq_pkg::ACT_POP_FRONT: begin
				if (is_empty) begin
					st_nxt = bdeq_pkg::ST_EMPTY;
				end else begin
					op_rd     = 1'b1;
					front_nxt = front_inc;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			bdeq_pkg::ACT_POP_BACK: begin
				if (is_empty) begin
					st_nxt = bdeq_pkg::ST_EMPTY;
				end else begin
					op_rd     = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			bdeq_pkg::ACT_READ: begin
				op_rd = 1'b1;
			end
			default: begin
			end
		endcase
		wr_en = (state_q == S_ACCESS) && op_wr;
		rd_en = (state_q == S_ACCESS) && op_rd;
	end

	// Sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE, S_DONE: begin
				if (req_accept) begin
					state_nxt = (req_data.action == bdeq_pkg::ACT_READ) ? S_MOD : S_ACCESS;
				end else if ((state_q == S_DONE) && !rsp_stall) begin
					state_nxt = S_IDLE;
				end
			end
			S_MOD: begin
				if (link[bdeq_pkg::IDX_W].valid) begin
					state_nxt = rd_miss ? S_DONE : S_ACCESS;
				end
			end
			S_ACCESS: begin
				state_nxt = op_rd ? S_FETCH : S_DONE;
			end
			S_FETCH: begin
				state_nxt = S_DONE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Control state: sequencer, pointers, count and capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			cap_q   <= bdeq_pkg::CAP_W'(CAP_RESET);
		end else begin
			state_q <= state_nxt;
			if (state_q == S_ACCESS) begin
				front_q <= front_nxt;
				count_q <= count_nxt;
			end else if (cfg_valid && (CMP_W'(count_q) > CMP_W'(cap_new))) begin
				// drop back entries that no longer fit
				count_q <= CNT_W'(cap_new);
			end
			if (cfg_valid) begin
				cap_q <= cap_new;
			end
		end
	end

	// Request hold and response register.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			act_q    <= req_data.action;
			item_q   <= req_data.item_value;
			offset_q <= offset_new;
		end
		case (state_q)
			S_MOD: begin
				if (link[bdeq_pkg::IDX_W].valid) begin
					offset_q                <= CNT_W'(link[bdeq_pkg::IDX_W].rem);
					rsp_q.read_value        <= '0;
					rsp_q.status            <= bdeq_pkg::ST_EMPTY;
					rsp_q.element_count     <= bdeq_pkg::CAP_W'(count_q);
				end
			end
			S_ACCESS: begin
				rsp_q.read_value    <= '0;
				rsp_q.status        <= st_nxt;
				rsp_q.element_count <= bdeq_pkg::CAP_W'(count_nxt);
			end
			S_FETCH: begin
				rsp_q.read_value <= bdeq_pkg::VAL_W'(rd_data);
			end
			default: begin
			end
		endcase
	end

	bdeq_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ring_addr),
		.wr_data (DATA_WIDTH'(item_q)),
		.rd_en   (rd_en),
		.rd_addr (ring_addr),
		.rd_data (rd_data)
	);

`ifndef SYNTHESIS
	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(cap_q))
		else $error("element count above capacity");

	a_chain_only_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		link[bdeq_pkg::IDX_W].valid |-> (state_q == S_MOD))
		else $error("modulo result outside the modulo wait");

	a_rem_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		link[bdeq_pkg::IDX_W].valid |-> (link[bdeq_pkg::IDX_W].rem < cap_q))
		else $error("modulo remainder not below capacity");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != S_ACCESS) && !cfg_valid) |=> $stable(count_q))
		else $error("count changed outside access or configuration");
`endif

endmodule

`default_nettype wire

@@ sim/tb_bounded_double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue: self-checking bench for the bounded deque
// Drives push, pop and indexed-read requests through the valid/stall request
// channel and rewrites the capacity register between phases. A shadow deque
// in the bench predicts every response; the response monitor compares each
// accepted response field by field against the oldest prediction. The run
// covers directed corner cases, a capacity sweep with random traffic under
// several idle and stall patterns, and a fill-to-full pass under a long
// response hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_double_ended_queue;

	localparam int RING_DEPTH      = 256;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int CFG_SETTLE      = 4;
	localparam int END_SETTLE      = 20;

	logic                           clk;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_stall;
	bdeq_pkg::bdeq_req_t            req_data;
	logic                           rsp_valid;
	logic                           rsp_stall;
	bdeq_pkg::bdeq_rsp_t            rsp_data;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [bdeq_pkg::CAP_W-1:0]     cfg_data;

	// Shadow deque: ring contents, front slot, element count and capacity.
	logic [bdeq_pkg::VAL_W-1:0]     shadow_ring [RING_DEPTH];
	logic [7:0]                     shadow_front;
	logic [bdeq_pkg::CAP_W-1:0]     shadow_count;
	logic [bdeq_pkg::CAP_W-1:0]     shadow_capacity;

	// Predicted responses, oldest first.
	bdeq_pkg::bdeq_rsp_t            pending_rsp_q [$];

	int                             mismatch_count;
	int                             send_idle_pct;
	int                             rsp_stall_pct;
	int                             rsp_hold_left;

	bounded_double_ended_queue #(
		.DEPTH      (RING_DEPTH),
		.DATA_WIDTH (bdeq_pkg::VAL_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Shadow deque
	// ------------------------------------------------------------------------

	// Map a raw register value onto the range the block honors: zero acts as
	// one and anything above the ring depth acts as the ring depth.
	function automatic logic [bdeq_pkg::CAP_W-1:0] effective_capacity(
			input logic [bdeq_pkg::CAP_W-1:0] raw);
		if (raw == '0)
			return 9'd1;
		if (raw > 9'(RING_DEPTH))
			return 9'(RING_DEPTH);
		return raw;
	endfunction

	// Apply one request to the shadow deque and return the response it earns.
	function automatic bdeq_pkg::bdeq_rsp_t predict_response(input bdeq_pkg::bdeq_req_t r);
		bdeq_pkg::bdeq_rsp_t        rsp;
		logic [7:0]                 slot;
		logic [bdeq_pkg::CAP_W-1:0] logical;
		rsp        = '0;
		rsp.status = bdeq_pkg::ST_OK;
		case (r.action)
			bdeq_pkg::ACT_PUSH_FRONT: begin
				if (shadow_count >= shadow_capacity) begin
					rsp.status = bdeq_pkg::ST_FULL;
				end else begin
					shadow_front              = shadow_front - 8'd1;
					shadow_ring[shadow_front] = r.item_value;
					shadow_count              = shadow_count + 9'd1;
				end
			end
			bdeq_pkg::ACT_PUSH_BACK: begin
				if (shadow_count >= shadow_capacity) begin
					rsp.status = bdeq_pkg::ST_FULL;
				end else begin
					// Write just past the last element.
					slot              = shadow_front + shadow_count[7:0];
					shadow_ring[slot] = r.item_value;
					shadow_count      = shadow_count + 9'd1;
				end
			end
			bdeq_pkg::ACT_POP_FRONT: begin
				if (shadow_count == '0) begin
					rsp.status = bdeq_pkg::ST_EMPTY;
				end else begin
					rsp.read_value = shadow_ring[shadow_front];
					shadow_front   = shadow_front + 8'd1;
					shadow_count   = shadow_count - 9'd1;
				end
			end
			bdeq_pkg::ACT_POP_BACK: begin
				if (shadow_count == '0) begin
					rsp.status = bdeq_pkg::ST_EMPTY;
				end else begin
					// A full ring of 256 wraps the low count bits to zero,
					// so minus one still lands on the last slot.
					slot           = shadow_front + shadow_count[7:0] - 8'd1;
					rsp.read_value = shadow_ring[slot];
					shadow_count   = shadow_count - 9'd1;
				end
			end
			bdeq_pkg::ACT_READ: begin
				logical = 9'(r.read_index % shadow_capacity);
				if (logical >= shadow_count) begin
					rsp.status = bdeq_pkg::ST_EMPTY;
				end else begin
					slot           = shadow_front + logical[7:0];
					rsp.read_value = shadow_ring[slot];
				end
			end
			default: begin
				// Unused codes leave the deque alone and answer ok.
			end
		endcase
		rsp.element_count = shadow_count;
		return rsp;
	endfunction

	// ------------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------------

	function automatic bdeq_pkg::bdeq_req_t make_req(
			input logic [bdeq_pkg::ACT_W-1:0] action,
			input logic [bdeq_pkg::VAL_W-1:0] value,
			input logic [bdeq_pkg::IDX_W-1:0] index);
		bdeq_pkg::bdeq_req_t r;
		r.action     = action;
		r.item_value = value;
		r.read_index = index;
		return r;
	endfunction

	// Build a random request. Filling favors pushes, draining favors pops.
	// Half the reads aim at a logical position plus a multiple of the
	// capacity, the rest use any 16-bit index.
	function automatic bdeq_pkg::bdeq_req_t random_request(input bit filling);
		bdeq_pkg::bdeq_req_t r;
		int                  pick;
		int                  logical;
		int                  wraps;
		r.item_value = $urandom;
		if ($urandom_range(1) == 0) begin
			r.read_index = 16'($urandom_range(65535));
		end else begin
			logical      = $urandom_range(shadow_capacity - 1);
			wraps        = $urandom_range((65535 - logical) / shadow_capacity);
			r.read_index = 16'(logical + wraps * shadow_capacity);
		end
		pick = $urandom_range(99);
		if (pick < 3)
			r.action = 3'($urandom_range(7, 5));
		else if (pick < 15)
			r.action = bdeq_pkg::ACT_READ;
		else if (filling ? (pick < 73) : (pick >= 73))
			r.action = $urandom_range(1) ? bdeq_pkg::ACT_PUSH_FRONT : bdeq_pkg::ACT_PUSH_BACK;
		else
			r.action = $urandom_range(1) ? bdeq_pkg::ACT_POP_FRONT : bdeq_pkg::ACT_POP_BACK;
		return r;
	endfunction

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
	endtask

	// Offer one request and hold it until the block takes it. Valid stays
	// high on return so a back-to-back request needs no gap; whoever stops
	// sending lowers it.
	task automatic send_request(input bdeq_pkg::bdeq_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsp_q.push_back(predict_response(r));
	endtask

	// Stop sending, wait for every predicted response, then let the block
	// settle.
	task automatic wait_for_idle(input int settle);
		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (settle)
			@(posedge clk);
	endtask

	// Write the capacity register while the block is idle.
	task automatic write_capacity(input logic [bdeq_pkg::CAP_W-1:0] raw);
		wait_for_idle(CFG_SETTLE);
		cfg_valid <= 1'b1;
		cfg_data  <= raw;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_capacity = effective_capacity(raw);
		// Lowering the capacity drops elements at the back.
		if (shadow_count > shadow_capacity)
			shadow_count = shadow_capacity;
	endtask

	// ------------------------------------------------------------------------
	// Response side: stall pattern and monitor
	// ------------------------------------------------------------------------

	// Stall at the configured rate; a pending hold-off forces a long stall
	// and is counted down here one cycle at a time.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_left > 0) begin
				rsp_stall     <= 1'b1;
				rsp_hold_left = rsp_hold_left - 1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
			end
		end
	end

	// Compare every accepted response with the oldest prediction.
	initial begin
		bdeq_pkg::bdeq_rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_rsp_q.size() == 0) begin
					$error("response with none predicted: value %h status %0d count %0d",
						rsp_data.read_value, rsp_data.status, rsp_data.element_count);
					mismatch_count++;
				end else begin
					want = pending_rsp_q.pop_front();
					if (rsp_data.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h",
							want.read_value, rsp_data.read_value);
						mismatch_count++;
					end
					if (rsp_data.status !== want.status) begin
						$error("status: expected %0d, got %0d",
							want.status, rsp_data.status);
						mismatch_count++;
					end
					if (rsp_data.element_count !== want.element_count) begin
						$error("element_count: expected %0d, got %0d",
							want.element_count, rsp_data.element_count);
						mismatch_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Corner cases: empty pops and reads, extreme values and indexes, every
	// action code, capacity at one, zero and above the ring depth, and a
	// capacity cut that drops back elements.
	task automatic test_directed_edges();
		int code;
		set_idling(0, 0);
		send_request(make_req(bdeq_pkg::ACT_POP_FRONT, 32'h0, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_POP_BACK, 32'hFFFF_FFFF, 16'hFFFF));
		send_request(make_req(bdeq_pkg::ACT_READ, 32'h0, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF, 16'hFFFF));
		// Push front from slot 0 wraps the front pointer to the top.
		send_request(make_req(bdeq_pkg::ACT_PUSH_FRONT, 32'h0, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_PUSH_BACK, 32'hA5A5_5A5A, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_READ, 32'h0, 16'd0));
		// Index 65535 maps to 255, past the last element.
		send_request(make_req(bdeq_pkg::ACT_READ, 32'h0, 16'hFFFF));
		send_request(make_req(bdeq_pkg::ACT_READ, 32'hFFFF_FFFF, 16'd258));
		// Reset capacity of 256 folds index 256 back onto the front.
		send_request(make_req(bdeq_pkg::ACT_READ, 32'h0, 16'd256));
		for (code = 5; code <= 7; code++)
			send_request(make_req(3'(code), 32'hFFFF_FFFF, 16'hFFFF));
		send_request(make_req(bdeq_pkg::ACT_POP_BACK, 32'h0, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_POP_FRONT, 32'h0, 16'h0));
		// Capacity one with one element held: both pushes are full.
		write_capacity(9'd1);
		send_request(make_req(bdeq_pkg::ACT_PUSH_FRONT, 32'h1111_1111, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_PUSH_BACK, 32'h2222_2222, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_READ, 32'h0, 16'hFFFF));
		// A written zero acts as one.
		write_capacity(9'd0);
		send_request(make_req(bdeq_pkg::ACT_PUSH_BACK, 32'h3333_3333, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_READ, 32'h0, 16'd1));
		// The largest register value acts as the ring depth.
		write_capacity(9'h1FF);
		send_request(make_req(bdeq_pkg::ACT_PUSH_FRONT, 32'h1234_5678, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_PUSH_BACK, 32'h8765_4321, 16'h0));
		// Cut three elements to two: the back one is dropped.
		write_capacity(9'd2);
		send_request(make_req(bdeq_pkg::ACT_READ, 32'h0, 16'd1));
		send_request(make_req(bdeq_pkg::ACT_POP_BACK, 32'h0, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_POP_FRONT, 32'h0, 16'h0));
		send_request(make_req(bdeq_pkg::ACT_POP_FRONT, 32'h0, 16'h0));
		write_capacity(9'd256);
	endtask

	// Random traffic in alternating fill and drain bursts over a sweep of
	// capacities, rotating through the idle and stall patterns.
	task automatic test_capacity_sweep();
		logic [bdeq_pkg::CAP_W-1:0] caps [8];
		int                         send_pct_tab [4];
		int                         stall_pct_tab [4];
		int                         phase;
		int                         sent;
		int                         burst_left;
		bit                         filling;
		caps          = '{9'd256, 9'd1, 9'd2, 9'd8, 9'd255, 9'h1FF, 9'd0, 9'd100};
		send_pct_tab  = '{0, 59, 0, 11};
		stall_pct_tab = '{0, 0, 59, 11};
		caps[3] = 9'($urandom_range(40, 3));
		caps[7] = 9'($urandom_range(511, 1));
		for (phase = 0; phase < 8; phase++) begin
			write_capacity(caps[phase]);
			set_idling(send_pct_tab[phase % 4], stall_pct_tab[phase % 4]);
			filling    = 1'b0;
			burst_left = 0;
			for (sent = 0; sent < ITEMS_PER_PHASE; sent++) begin
				if (burst_left == 0) begin
					filling    = !filling;
					burst_left = $urandom_range(2 * shadow_capacity + 2, 1);
				end
				send_request(random_request(filling));
				burst_left--;
			end
		end
	endtask

	// Fill the ring to full at the largest capacity while the response side
	// holds off, so requests back up; then pause, read around, and drain
	// past empty.
	task automatic test_full_backpressure();
		bdeq_pkg::bdeq_req_t r;
		int                  n;
		write_capacity(9'd256);
		set_idling(0, 0);
		rsp_hold_left = 300;
		for (n = 0; n < 270; n++) begin
			r        = random_request(1'b1);
			r.action = $urandom_range(1) ? bdeq_pkg::ACT_PUSH_FRONT : bdeq_pkg::ACT_PUSH_BACK;
			send_request(r);
		end
		// Pause the request side until every response is back.
		wait_for_idle(CFG_SETTLE);
		set_idling(11, 11);
		for (n = 0; n < 40; n++) begin
			r        = random_request(1'b1);
			r.action = bdeq_pkg::ACT_READ;
			send_request(r);
		end
		set_idling(0, 59);
		for (n = 0; n < 270; n++) begin
			r        = random_request(1'b0);
			r.action = $urandom_range(1) ? bdeq_pkg::ACT_POP_FRONT : bdeq_pkg::ACT_POP_BACK;
			send_request(r);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		mismatch_count  = 0;
		rsp_hold_left   = 0;
		send_idle_pct   = 0;
		rsp_stall_pct   = 0;
		shadow_front    = '0;
		shadow_count    = '0;
		shadow_capacity = 9'(RING_DEPTH);
		foreach (shadow_ring[i])
			shadow_ring[i] = '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_capacity_sweep();
		test_full_backpressure();

		wait_for_idle(END_SETTLE);
		if (mismatch_count == 0 && pending_rsp_q.size() == 0)
			$display("[bounded_double_ended_queue] OK");
		else
			$display("[bounded_double_ended_queue] ERROR");
		$finish;
	end

	// Watchdog: end a hung run well beyond the slowest correct one.
	initial begin
		#10_000_000;
		$display("[bounded_double_ended_queue] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
